[hw/rtl/dsrc_pkg.sv]
// Shared constants and types for the drive speed ramp controller.
`default_nettype none

package dsrc_pkg;

    localparam int FREQ_W     = 16;
    localparam int DIV_W      = 30;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int SPEED_SHIFT = 14;

    localparam logic [FREQ_W-1:0] MAX_FLOOR    = 16'd100;
    localparam logic [FREQ_W-1:0] MAX_DEFAULT  = 16'd5000;
    localparam logic [FREQ_W-1:0] TIME_DEFAULT = 16'd100;
    localparam logic [FREQ_W-1:0] MIN_DEFAULT  = 16'd0;

    localparam logic [2:0] CMD_DECEL = 3'd1;
    localparam logic [2:0] CMD_HOLD  = 3'd2;
    localparam logic [2:0] CMD_ACCEL = 3'd3;

    localparam int CW_RESET_BIT  = 7;
    localparam int CW_ENABLE_BIT = 10;

    localparam logic [1:0] REG_MAX_FREQ   = 2'd0;
    localparam logic [1:0] REG_MIN_FREQ   = 2'd1;
    localparam logic [1:0] REG_ACCEL_TIME = 2'd2;
    localparam logic [1:0] REG_DECEL_TIME = 2'd3;

    localparam logic [14:0] SCALED_SAT  = 15'd32767;
    localparam logic [7:0]  VOLTS_SAT   = 8'd255;
    localparam logic [5:0]  CURRENT_SAT = 6'd63;
    localparam logic [7:0]  VOLTS_GAIN   = 8'd220;
    localparam logic [5:0]  CURRENT_GAIN = 6'd50;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [FREQ_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/dsrc_div.sv]
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none

module dsrc_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dsrc_pkg::div_req_t req,
    output dsrc_pkg::div_rsp_t      rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [dsrc_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [dsrc_pkg::FREQ_W-1:0]       rem_reg;
    logic [dsrc_pkg::DIV_W-1:0]        quo_reg;
    logic [dsrc_pkg::FREQ_W-1:0]       divisor_reg;

    logic [dsrc_pkg::FREQ_W:0] rem_shift;
    logic [dsrc_pkg::FREQ_W:0] rem_diff;
    logic                      fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[dsrc_pkg::DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = rem_shift >= {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= dsrc_pkg::DIV_CNT_W'(dsrc_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - dsrc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == dsrc_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[dsrc_pkg::FREQ_W-1:0] : rem_shift[dsrc_pkg::FREQ_W-1:0];
            quo_reg <= {quo_reg[dsrc_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/drive_speed_ramp_controller.sv]
// Top level of the drive speed ramp controller: sequencer, state and configuration.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    frame, control word, speed ref, fault
//   m_        out        m_valid / m_ready    flags, telemetry, fault code, target
//   APB       in         psel/penable/pready  four 16-bit registers at 0x0..0xC
//
// A request passes through the idle, multiply and target states, two step divisions, the ramp
// state and three scaling divisions, all five on the shared divider (each loads its operands
// and then produces a 30-bit quotient), and the output state; s_ready is high only in idle.
// Reset is synchronous and active low and restores the register defaults.
// A finished result waits in the output registers while the next request is taken;
// the block stalls before its final load only when that result is still not taken.
`default_nettype none

module drive_speed_ramp_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_frame_valid,
    input  wire logic [15:0] s_control_word,
    input  wire logic signed [15:0] s_speed_ref,
    input  wire logic [15:0] s_fault_event,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_fault_active,
    output logic             m_running,
    output logic             m_zero_speed,
    output logic             m_speed_reached,
    output logic             m_accelerating,
    output logic             m_decelerating,
    output logic [14:0]      m_actual_scaled,
    output logic [15:0]      m_output_freq_chz,
    output logic [7:0]       m_output_volts,
    output logic [5:0]       m_output_current_da,
    output logic [15:0]      m_fault_code_out,
    output logic [15:0]      m_target_freq_chz,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_TGT, ST_UP, ST_DN, ST_RAMP, ST_SCL, ST_VLT, ST_CUR, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_STOPPED, PH_ON_TARGET, PH_UP, PH_DOWN
    } phase_t;

    logic [15:0] max_freq_reg;
    logic [15:0] min_freq_reg;
    logic [15:0] accel_time_reg;
    logic [15:0] decel_time_reg;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [15:0] fault_code_reg;
    logic        prev_reset_reg;
    logic [15:0] target_reg;
    logic [15:0] cur_reg;

    logic        frame_reg;
    logic [15:0] cw_reg;
    logic [15:0] speed_reg;
    logic [15:0] fault_event_reg;
    logic [30:0] prod_reg;
    logic [15:0] up_reg;
    logic [15:0] dn_reg;
    logic [14:0] scaled_reg;
    logic [7:0]  volts_reg;
    logic [5:0]  amps_reg;

    logic        m_valid_reg;
    logic        m_fault_active_reg;
    logic        m_running_reg;
    logic        m_reached_reg;
    logic        m_accel_reg;
    logic        m_decel_reg;
    logic [14:0] m_scaled_reg;
    logic [15:0] m_freq_reg;
    logic [7:0]  m_volts_reg;
    logic [5:0]  m_amps_reg;
    logic [15:0] m_fault_code_reg;
    logic [15:0] m_target_reg;

    dsrc_pkg::div_req_t div_req_reg;
    dsrc_pkg::div_rsp_t div_rsp;

    logic [15:0] mx_eff;
    logic [15:0] tt_eff;
    logic [15:0] td_eff;
    logic [16:0] ref_raw;
    logic [15:0] ref_val;
    logic [15:0] target_frame;
    logic [15:0] fault_code_next;
    logic [15:0] target_next;
    logic [15:0] cur_next;
    phase_t      phase_next;
    logic [15:0] step_q;
    logic        out_free;
    logic        cfg_write;
    logic        div_start_next;

    dsrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    always_comb begin
        mx_eff  = (max_freq_reg < dsrc_pkg::MAX_FLOOR) ? dsrc_pkg::MAX_DEFAULT : max_freq_reg;
        tt_eff  = (accel_time_reg == 16'd0) ? dsrc_pkg::TIME_DEFAULT : accel_time_reg;
        td_eff  = (decel_time_reg == 16'd0) ? dsrc_pkg::TIME_DEFAULT : decel_time_reg;

        ref_raw = prod_reg[30:dsrc_pkg::SPEED_SHIFT];
        if (speed_reg[15]) begin
            ref_val = 16'd0;
        end else if (ref_raw > {1'b0, mx_eff}) begin
            ref_val = mx_eff;
        end else begin
            ref_val = ref_raw[15:0];
        end

        if (!cw_reg[dsrc_pkg::CW_ENABLE_BIT]) begin
            target_frame = 16'd0;
        end else begin
            case (cw_reg[2:0])
                dsrc_pkg::CMD_ACCEL: begin
                    target_frame = (ref_val != 16'd0 && ref_val < min_freq_reg) ?
                                   min_freq_reg : ref_val;
                end
                dsrc_pkg::CMD_DECEL: target_frame = min_freq_reg;
                dsrc_pkg::CMD_HOLD:  target_frame = cur_reg;
                default:             target_frame = 16'd0;
            endcase
        end

        fault_code_next = fault_code_reg;
        if (frame_reg && cw_reg[dsrc_pkg::CW_RESET_BIT] && !prev_reset_reg) begin
            fault_code_next = 16'd0;
        end
        if (fault_event_reg != 16'd0) begin
            fault_code_next = fault_event_reg;
        end
        if (fault_code_next != 16'd0) begin
            target_next = 16'd0;
        end else begin
            target_next = frame_reg ? target_frame : target_reg;
        end

        if (target_reg > cur_reg && (target_reg - cur_reg) > up_reg) begin
            cur_next   = cur_reg + up_reg;
            phase_next = PH_UP;
        end else if (cur_reg > target_reg && (cur_reg - target_reg) > dn_reg) begin
            cur_next   = cur_reg - dn_reg;
            phase_next = PH_DOWN;
        end else begin
            cur_next   = target_reg;
            phase_next = (target_reg == 16'd0) ? PH_STOPPED : PH_ON_TARGET;
        end

        if (div_rsp.quotient == '0) begin
            step_q = 16'd1;
        end else begin
            step_q = div_rsp.quotient[15:0];
        end

        case (state_reg)
            ST_TGT, ST_RAMP:       div_start_next = 1'b1;
            ST_UP, ST_SCL, ST_VLT: div_start_next = div_rsp.done;
            default:               div_start_next = 1'b0;
        endcase

        out_free  = !m_valid_reg || m_ready;
        cfg_write = psel && penable && pwrite;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_freq_reg   <= dsrc_pkg::MAX_DEFAULT;
            min_freq_reg   <= dsrc_pkg::MIN_DEFAULT;
            accel_time_reg <= dsrc_pkg::TIME_DEFAULT;
            decel_time_reg <= dsrc_pkg::TIME_DEFAULT;
        end else if (cfg_write) begin
            case (paddr[3:2])
                dsrc_pkg::REG_MAX_FREQ:   max_freq_reg   <= pwdata[15:0];
                dsrc_pkg::REG_MIN_FREQ:   min_freq_reg   <= pwdata[15:0];
                dsrc_pkg::REG_ACCEL_TIME: accel_time_reg <= pwdata[15:0];
                dsrc_pkg::REG_DECEL_TIME: decel_time_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dsrc_pkg::REG_MAX_FREQ:   prdata = {16'd0, max_freq_reg};
            dsrc_pkg::REG_MIN_FREQ:   prdata = {16'd0, min_freq_reg};
            dsrc_pkg::REG_ACCEL_TIME: prdata = {16'd0, accel_time_reg};
            dsrc_pkg::REG_DECEL_TIME: prdata = {16'd0, decel_time_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_STOPPED;
            fault_code_reg    <= 16'd0;
            prev_reset_reg    <= 1'b0;
            target_reg        <= 16'd0;
            cur_reg           <= 16'd0;
            m_valid_reg       <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            div_req_reg.start <= div_start_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        frame_reg       <= s_frame_valid;
                        cw_reg          <= s_control_word;
                        speed_reg       <= s_speed_ref;
                        fault_event_reg <= s_fault_event;
                        state_reg       <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= speed_reg[14:0] * mx_eff;
                    state_reg <= ST_TGT;
                end
                ST_TGT: begin
                    fault_code_reg <= fault_code_next;
                    target_reg     <= target_next;
                    if (frame_reg) begin
                        prev_reset_reg <= cw_reg[dsrc_pkg::CW_RESET_BIT];
                    end
                    div_req_reg.dividend <= dsrc_pkg::DIV_W'(mx_eff);
                    div_req_reg.divisor  <= tt_eff;
                    state_reg            <= ST_UP;
                end
                ST_UP: begin
                    if (div_rsp.done) begin
                        up_reg               <= step_q;
                        div_req_reg.dividend <= dsrc_pkg::DIV_W'(mx_eff);
                        div_req_reg.divisor  <= td_eff;
                        state_reg            <= ST_DN;
                    end
                end
                ST_DN: begin
                    if (div_rsp.done) begin
                        dn_reg    <= step_q;
                        state_reg <= ST_RAMP;
                    end
                end
                ST_RAMP: begin
                    cur_reg              <= cur_next;
                    phase_reg            <= phase_next;
                    div_req_reg.dividend <= {cur_next, 14'd0};
                    div_req_reg.divisor  <= mx_eff;
                    state_reg            <= ST_SCL;
                end
                ST_SCL: begin
                    if (div_rsp.done) begin
                        scaled_reg <= (div_rsp.quotient > dsrc_pkg::DIV_W'(dsrc_pkg::SCALED_SAT)) ?
                                      dsrc_pkg::SCALED_SAT : div_rsp.quotient[14:0];
                        div_req_reg.dividend <= dsrc_pkg::DIV_W'(cur_reg) *
                                                dsrc_pkg::DIV_W'(dsrc_pkg::VOLTS_GAIN);
                        div_req_reg.divisor  <= mx_eff;
                        state_reg            <= ST_VLT;
                    end
                end
                ST_VLT: begin
                    if (div_rsp.done) begin
                        volts_reg <= (div_rsp.quotient > dsrc_pkg::DIV_W'(dsrc_pkg::VOLTS_SAT)) ?
                                     dsrc_pkg::VOLTS_SAT : div_rsp.quotient[7:0];
                        div_req_reg.dividend <= dsrc_pkg::DIV_W'(cur_reg) *
                                                dsrc_pkg::DIV_W'(dsrc_pkg::CURRENT_GAIN);
                        div_req_reg.divisor  <= mx_eff;
                        state_reg            <= ST_CUR;
                    end
                end
                ST_CUR: begin
                    if (div_rsp.done) begin
                        amps_reg  <= (div_rsp.quotient > dsrc_pkg::DIV_W'(dsrc_pkg::CURRENT_SAT)) ?
                                     dsrc_pkg::CURRENT_SAT : div_rsp.quotient[5:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_fault_active_reg <= fault_code_reg != 16'd0;
                        m_running_reg      <= cur_reg > 16'd1;
                        m_reached_reg      <= phase_reg == PH_ON_TARGET && cur_reg > 16'd1;
                        m_accel_reg        <= phase_reg == PH_UP;
                        m_decel_reg        <= phase_reg == PH_DOWN;
                        m_scaled_reg       <= scaled_reg;
                        m_freq_reg         <= cur_reg;
                        m_volts_reg        <= volts_reg;
                        m_amps_reg         <= amps_reg;
                        m_fault_code_reg   <= fault_code_reg;
                        m_target_reg       <= target_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready             = state_reg == ST_IDLE;
    assign m_valid             = m_valid_reg;
    assign m_fault_active      = m_fault_active_reg;
    assign m_running           = m_running_reg;
    assign m_zero_speed        = !m_running_reg;
    assign m_speed_reached     = m_reached_reg;
    assign m_accelerating      = m_accel_reg;
    assign m_decelerating      = m_decel_reg;
    assign m_actual_scaled     = m_scaled_reg;
    assign m_output_freq_chz   = m_freq_reg;
    assign m_output_volts      = m_volts_reg;
    assign m_output_current_da = m_amps_reg;
    assign m_fault_code_out    = m_fault_code_reg;
    assign m_target_freq_chz   = m_target_reg;

endmodule

`default_nettype wire
